// ===== design/record_ring_drop_oldest_defines.svh =====
// assertion macros for the record ring
// no dependencies
`ifndef RECORD_RING_DROP_OLDEST_DEFINES_SVH
`define RECORD_RING_DROP_OLDEST_DEFINES_SVH
`define RRDO_ASSERT_IMPL(label, clk, rst, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error(msg);
`define RRDO_ASSERT_NEXT(label, clk, rst, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error(msg);
`endif

// ===== design/rrdo_pkg.sv =====
// shared constants and word types for the record ring
// no dependencies
package rrdo_pkg;
  localparam int RING_BYTES = 4096;
  localparam int AW = $clog2(RING_BYTES);
  localparam int UW = AW + 1;
  localparam logic [15:0] MAX_NOTE_LEN = 16'd120;
  localparam logic [3:0] NOTE_HDR = 4'd7;
  localparam logic [3:0] FRAME_HDR = 4'd12;

  typedef enum logic [2:0] {
    F_BEGIN_FRAME = 3'd0,
    F_BEGIN_NOTE  = 3'd1,
    F_DATA        = 3'd2,
    F_DRAIN_HDR   = 3'd3,
    F_DRAIN_BYTE  = 3'd4,
    F_CLEAR       = 3'd5
  } func_t;

  typedef struct packed {
    logic [2:0]  func;
    logic [31:0] stamp;
    logic [15:0] rec_len;
    logic [31:0] gap;
    logic        check_ok;
    logic [7:0]  in_byte;
  } in_word_t;

  typedef struct packed {
    logic        ok;
    logic        empty_res;
    logic        kind;
    logic [31:0] stamp_out;
    logic [15:0] len_out;
    logic [31:0] gap_out;
    logic        check_out;
    logic [7:0]  out_byte;
    logic        last_byte;
    logic [9:0]  frame_count;
    logic [9:0]  note_count;
    logic [31:0] evicted_total;
  } out_word_t;
endpackage

// ===== design/rrdo_if.sv =====
// valid/ready channel carrying one word
// depends on rrdo_pkg
interface rrdo_in_if import rrdo_pkg::*; ();
  logic valid;
  logic ready;
  in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface rrdo_out_if import rrdo_pkg::*; ();
  logic valid;
  logic ready;
  out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== design/record_ring_drop_oldest.sv =====
// byte ring of variable-length records, oldest dropped when short of room
// depends on rrdo_pkg, rrdo_if, record_ring_drop_oldest_defines.svh
//
//  channel  dir  payload
//  in       in   func stamp rec_len gap check_ok in_byte
//  out      out  ok empty_res kind stamp/len/gap/check out_byte last ... counts
//
// one word at a time through a sequencer around a single byte ram
// data byte written on acceptance; drain header waits then reads each header byte in turn
// begin: evicts oldest records while short of room, then writes its header bytes one by one
// an unfinished record is zero filled byte by byte before each begin or drain
// next word accepted only after the result word is taken
// rst (synchronous) clears control state; ram contents stay undefined
`include "record_ring_drop_oldest_defines.svh"
module record_ring_drop_oldest import rrdo_pkg::*; (
  input logic clk,
  input logic rst,
  rrdo_in_if.sink in,
  rrdo_out_if.source out
);
  typedef enum logic [3:0] {
    S_IDLE, S_FILL, S_DISC, S_DISPATCH, S_EVRD, S_EVWT, S_HDRWR,
    S_DHRD, S_DHWT, S_DBWT, S_OUT
  } state_t;

  logic [7:0] ram [RING_BYTES];
  logic [7:0] rdata;
  logic [AW-1:0] raddr, waddr;
  logic [7:0] wdata;
  logic we;

  state_t state;
  in_word_t cmd;
  out_word_t res;
  logic [AW-1:0] head;
  logic [UW-1:0] used;
  logic [9:0] frames, notes;
  logic [31:0] evictions;
  logic [15:0] wleft, wskip, rleft;
  logic rkind;
  logic [3:0] idx;
  logic [15:0] len_c, skip_c;
  logic [16:0] need;
  logic [7:0] ev_type;
  logic [7:0] ev_len;
  logic [7:0] hb;
  logic [7:0] ob;
  logic byte_pend;

  always_ff @(posedge clk) begin
    if (we) ram[waddr] <= wdata;
    rdata <= ram[raddr];
  end

  assign in.ready = (state == S_IDLE) && !out.valid;
  assign out.data = res;

  logic is_frame;
  assign is_frame = cmd.func == F_BEGIN_FRAME;

  always_comb begin
    len_c = cmd.rec_len;
    skip_c = '0;
    if (!is_frame && cmd.rec_len > MAX_NOTE_LEN) begin
      len_c = MAX_NOTE_LEN;
      skip_c = cmd.rec_len - MAX_NOTE_LEN;
    end
    need = 17'(is_frame ? FRAME_HDR : NOTE_HDR) + 17'(len_c);
  end

  always_comb begin
    unique case (idx)
      4'd0: hb = is_frame ? 8'd0 : 8'd1;
      4'd1: hb = cmd.stamp[7:0];
      4'd2: hb = cmd.stamp[15:8];
      4'd3: hb = cmd.stamp[23:16];
      4'd4: hb = cmd.stamp[31:24];
      4'd5: hb = len_c[7:0];
      4'd6: hb = len_c[15:8];
      4'd7: hb = cmd.gap[7:0];
      4'd8: hb = cmd.gap[15:8];
      4'd9: hb = cmd.gap[23:16];
      4'd10: hb = cmd.gap[31:24];
      4'd11: hb = {7'd0, cmd.check_ok};
      default: hb = 8'd0;
    endcase
  end

  assign ob = (rkind && (rdata == 8'h0A || rdata == 8'h0D)) ? 8'h20 : rdata;
  assign byte_pend = idx == 4'd15 && cmd.func == F_DRAIN_BYTE && res.ok;

  logic [UW-1:0] wofs;
  always_comb begin
    we = 1'b0;
    waddr = '0;
    wdata = '0;
    raddr = head;
    wofs = used - UW'(wleft);
    if (state == S_FILL) begin
      we = wleft != 16'd0;
      waddr = head + wofs[AW-1:0];
    end else if (state == S_HDRWR) begin
      we = 1'b1;
      waddr = head + used[AW-1:0] + AW'(idx);
      wdata = hb;
    end else if (state == S_IDLE && in.valid && in.ready &&
                 in.data.func == F_DATA && wleft != 0) begin
      we = 1'b1;
      waddr = head + wofs[AW-1:0];
      wdata = in.data.in_byte;
    end
  end

  logic [UW-1:0] rl_cl;
  assign rl_cl = ({1'b0, rleft} > (17)'(used)) ? used : UW'(rleft);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out.valid <= 1'b0;
      head <= '0; used <= '0; frames <= '0; notes <= '0; evictions <= '0;
      wleft <= '0; wskip <= '0; rleft <= '0; rkind <= 1'b0; idx <= '0;
    end else begin
      if (out.valid && out.ready) out.valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in.valid && in.ready) begin
            cmd <= in.data;
            idx <= '0;
            if (in.data.func == F_DATA) begin
              res <= {(wleft != 0) || (wskip != 0), {($bits(out_word_t) - 1){1'b0}}};
              if (wleft != 0) wleft <= wleft - 16'd1;
              else if (wskip != 0) wskip <= wskip - 16'd1;
              state <= S_OUT;
            end else if (in.data.func == F_CLEAR) begin
              head <= '0; used <= '0; frames <= '0; notes <= '0; evictions <= '0;
              wleft <= '0; wskip <= '0; rleft <= '0;
              res <= {1'b1, {($bits(out_word_t) - 1){1'b0}}};
              state <= S_OUT;
            end else if (in.data.func == F_BEGIN_FRAME || in.data.func == F_BEGIN_NOTE ||
                         in.data.func == F_DRAIN_HDR || in.data.func == F_DRAIN_BYTE) begin
              res <= '0;
              state <= S_FILL;
            end else begin
              res <= '0;
              state <= S_OUT;
            end
          end
        end
        S_FILL: begin
          if (wleft != 0) wleft <= wleft - 16'd1;
          else state <= (cmd.func == F_DRAIN_BYTE) ? S_DISPATCH : S_DISC;
        end
        S_DISC: begin
          head <= head + rl_cl[AW-1:0];
          used <= used - rl_cl;
          rleft <= '0;
          state <= S_DISPATCH;
        end
        S_DISPATCH: begin
          if (cmd.func == F_DRAIN_BYTE) begin
            if (rleft != 0 && used != 0) state <= S_DBWT;
            else begin
              rleft <= '0;
              state <= S_OUT;
            end
          end else if (cmd.func == F_DRAIN_HDR) begin
            if (used != 0) state <= S_DHWT;
            else state <= S_OUT;
          end else begin
            if (need > 17'(RING_BYTES)) state <= S_OUT;
            else if (17'(RING_BYTES) - 17'(used) < need && used != 0) begin
              state <= S_EVWT;
            end else state <= S_HDRWR;
          end
        end
        S_EVWT: state <= S_EVRD;
        S_EVRD: begin
          head <= head + AW'(1);
          used <= used - UW'(1);
          if (idx == 4'd0) ev_type <= rdata;
          if (idx == 4'd5) ev_len <= rdata;
          if (idx == 4'd6) begin
            state <= S_DISC;
            cmd.func <= cmd.func;
            evictions <= evictions + 32'd1;
            if (ev_type == 8'd0) begin
              frames <= frames - 10'd1;
              rleft <= 16'd5 + {rdata, ev_len};
            end else begin
              notes <= notes - 10'd1;
              rleft <= {rdata, ev_len};
            end
            idx <= '0;
          end else begin
            idx <= idx + 4'd1;
            state <= S_EVWT;
          end
        end
        S_HDRWR: begin
          idx <= idx + 4'd1;
          if (idx == (is_frame ? FRAME_HDR : NOTE_HDR) - 4'd1) begin
            used <= used + need[UW-1:0];
            wleft <= len_c;
            wskip <= skip_c;
            if (is_frame) frames <= frames + 10'd1;
            else notes <= notes + 10'd1;
            res.ok <= 1'b1;
            state <= S_OUT;
          end
        end
        S_DHWT: state <= S_DHRD;
        S_DHRD: begin
          head <= head + AW'(1);
          used <= used - UW'(1);
          idx <= idx + 4'd1;
          unique case (idx)
            4'd0: rkind <= rdata != 8'd0;
            4'd1: res.stamp_out[7:0] <= rdata;
            4'd2: res.stamp_out[15:8] <= rdata;
            4'd3: res.stamp_out[23:16] <= rdata;
            4'd4: res.stamp_out[31:24] <= rdata;
            4'd5: res.len_out[7:0] <= rdata;
            4'd6: res.len_out[15:8] <= rdata;
            4'd7: res.gap_out[7:0] <= rdata;
            4'd8: res.gap_out[15:8] <= rdata;
            4'd9: res.gap_out[23:16] <= rdata;
            4'd10: res.gap_out[31:24] <= rdata;
            4'd11: res.check_out <= rdata != 8'd0;
            default: ;
          endcase
          if ((idx == 4'd6 && rkind) || idx == 4'd11) begin
            res.ok <= 1'b1;
            res.kind <= rkind;
            rleft <= (idx == 4'd6) ? {rdata, res.len_out[7:0]} : res.len_out;
            if (rkind) notes <= notes - 10'd1;
            else frames <= frames - 10'd1;
            state <= S_OUT;
          end else state <= S_DHWT;
        end
        S_DBWT: begin
          head <= head + AW'(1);
          used <= used - UW'(1);
          rleft <= rleft - 16'd1;
          res.ok <= 1'b1;
          res.kind <= rkind;
          res.last_byte <= rleft == 16'd1;
          state <= S_OUT;
          idx <= 4'd15;
        end
        S_OUT: begin
          if (byte_pend) begin
            res.out_byte <= ob;
            idx <= '0;
          end else begin
            res.empty_res <= used == '0;
            res.frame_count <= frames;
            res.note_count <= notes;
            res.evicted_total <= evictions;
            out.valid <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `RRDO_ASSERT_IMPL(a_used_bound, clk, rst, 1'b1, used <= UW'(RING_BYTES), "used exceeds ring")
  `RRDO_ASSERT_IMPL(a_no_accept_busy, clk, rst, state != S_IDLE, !in.ready, "accept while busy")
  `RRDO_ASSERT_NEXT(a_out_after, clk, rst, state == S_OUT && !byte_pend, out.valid, "no result")
endmodule
